// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define PADT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("padt assertion failed");

// Clocked assertion that also holds during reset
`define PADT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("padt assertion failed");

`endif

// ===== src/padt_pkg.sv =====
// Package for the periodic action divider table: sizes, codes and payload types.
// Used by every module of the block; depends on nothing.
package padt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [31:0] RESET_PERIOD = 32'd1000000;

    // Request types
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_FIRED     = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_REMOVED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] elapsed_us;
        logic [7:0]  action_id;
        logic [15:0] multiplier;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  fired_id;
        logic [47:0] interval_us;
        logic        last;
    } t_result;

    // One table entry
    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] multiple;
        logic [15:0] countdown;
    } t_entry;

    // Result request from the sequencer to the output stage
    typedef struct packed {
        logic        valid;
        logic [2:0]  status;
        logic [7:0]  id;
        logic [15:0] mult;
        logic        last;
    } t_emit;

endpackage

// ===== src/padt_table.sv =====
// Entry table of the divider: one write port, one combinational read port.
// Depends on padt_pkg.
module padt_table (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [padt_pkg::IDX_W-1:0] i_wr_addr,
    input  padt_pkg::t_entry        i_wr_data,
    input  logic [padt_pkg::IDX_W-1:0] i_rd_addr,
    output padt_pkg::t_entry        o_rd_data
);

    padt_pkg::t_entry r_mem [padt_pkg::TABLE_DEPTH];

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read the entry under the walk pointer
    assign o_rd_data = r_mem[i_rd_addr];

endmodule

// ===== src/padt_out.sv =====
// Result register of the divider: forms the interval and drives the strobe.
// Depends on padt_pkg.
module padt_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  padt_pkg::t_emit   i_emit,
    input  logic [31:0]       i_period,
    output logic              o_result_valid,
    output padt_pkg::t_result o_result
);

    logic [16:0] mult_p1;
    logic [47:0] product;

    // Interval is (multiplier + 1) * period
    assign mult_p1 = {1'b0, i_emit.mult} + 17'd1;
    assign product = 48'(mult_p1) * 48'(i_period);

    // Strobe: control state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_emit.valid;
        end
    end

    // Hold the payload of the last request
    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            o_result.status   <= i_emit.status;
            o_result.fired_id <= i_emit.id;
            o_result.last     <= i_emit.last;
            if (i_emit.status == padt_pkg::ST_FIRED) begin
                o_result.interval_us <= product;
            end else begin
                o_result.interval_us <= 48'd0;
            end
        end
    end

endmodule

// ===== src/periodic_action_divider_table_core.sv =====
// Periodic action divider table. A request is taken when start is high and busy is low.
// A tick that causes no impulse is handled in the idle state. An impulse walks the table
// one entry a cycle through the single table port and then releases the last result in a
// flush state (with an empty table it stays idle). An add or remove searches one entry a
// cycle, closes the gap one entry a cycle and, for an add, then appends. Each result
// shows on o_result for one cycle with o_result_valid, in the cycle after it is formed;
// the receiver cannot hold it off, and the last result of a request carries last. The
// period register may be written while idle.
// Depends on padt_pkg, padt_table and padt_out.
module periodic_action_divider_table_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  padt_pkg::t_req    i_req,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    output logic              o_result_valid,
    output padt_pkg::t_result o_result
);

    localparam int IW = padt_pkg::IDX_W;
    localparam int CW = padt_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_FLUSH,
        S_SEARCH,
        S_SHIFT,
        S_APPEND
    } t_state;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_base, n_base;
    logic [31:0]      r_period;
    padt_pkg::t_req   r_req, n_req;
    logic             r_pend_valid, n_pend_valid;
    logic [7:0]       r_pend_id, n_pend_id;
    logic [15:0]      r_pend_mult, n_pend_mult;

    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    padt_pkg::t_entry wr_data;
    logic [IW-1:0]    rd_addr;
    padt_pkg::t_entry rd_data;
    padt_pkg::t_emit  emit;
    logic             last_idx;

    assign busy     = (r_state != S_IDLE);
    assign last_idx = ((CW'(r_idx) + CW'(1)) >= r_count);

    // Sequencer: walk, flush, search, shift and append
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_count      = r_count;
        n_base       = r_base;
        n_req        = r_req;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_mult  = r_pend_mult;
        wr_en        = 1'b0;
        wr_addr      = r_idx;
        wr_data      = rd_data;
        rd_addr      = r_idx;
        emit         = '0;
        emit.id      = r_req.action_id;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    emit.id = i_req.action_id;
                    case (i_req.req_type)
                        padt_pkg::REQ_TICK: begin
                            if (r_base < i_req.elapsed_us) begin
                                n_base = r_period;
                                if (r_count != '0) begin
                                    n_pend_valid = 1'b0;
                                    n_state      = S_WALK;
                                end
                            end else begin
                                n_base = r_base - i_req.elapsed_us;
                            end
                        end
                        padt_pkg::REQ_ADD: begin
                            n_state = (r_count == '0) ? S_APPEND : S_SEARCH;
                        end
                        padt_pkg::REQ_REMOVE: begin
                            if (r_count == '0) begin
                                emit.valid  = 1'b1;
                                emit.status = padt_pkg::ST_NOT_FOUND;
                                emit.last   = 1'b1;
                            end else begin
                                n_state = S_SEARCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_WALK: begin
                // Fire or count down the current entry
                wr_en = 1'b1;
                if (rd_data.countdown == 16'd0) begin
                    wr_data.countdown = rd_data.multiple;
                    if (r_pend_valid) begin
                        emit.valid  = 1'b1;
                        emit.status = padt_pkg::ST_FIRED;
                        emit.id     = r_pend_id;
                        emit.mult   = r_pend_mult;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_id    = rd_data.ident;
                    n_pend_mult  = rd_data.multiple;
                end else begin
                    wr_data.countdown = rd_data.countdown - 16'd1;
                end
                if (last_idx) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_FLUSH: begin
                // Release the held firing as the final result
                if (r_pend_valid) begin
                    emit.valid  = 1'b1;
                    emit.status = padt_pkg::ST_FIRED;
                    emit.id     = r_pend_id;
                    emit.mult   = r_pend_mult;
                    emit.last   = 1'b1;
                end
                n_pend_valid = 1'b0;
                n_state      = S_IDLE;
            end

            S_SEARCH: begin
                if (rd_data.ident == r_req.action_id) begin
                    n_state = S_SHIFT;
                end else if (last_idx) begin
                    if (r_req.req_type == padt_pkg::REQ_ADD) begin
                        n_state = S_APPEND;
                    end else begin
                        emit.valid  = 1'b1;
                        emit.status = padt_pkg::ST_NOT_FOUND;
                        emit.last   = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end

            S_SHIFT: begin
                // Move the next entry down over the gap
                if (!last_idx) begin
                    rd_addr = r_idx + IW'(1);
                    wr_en   = 1'b1;
                    n_idx   = r_idx + IW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    if (r_req.req_type == padt_pkg::REQ_ADD) begin
                        n_state = S_APPEND;
                    end else begin
                        emit.valid  = 1'b1;
                        emit.status = padt_pkg::ST_REMOVED;
                        emit.last   = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end

            S_APPEND: begin
                emit.valid = 1'b1;
                emit.last  = 1'b1;
                if (r_count >= CW'(padt_pkg::TABLE_DEPTH)) begin
                    emit.status = padt_pkg::ST_FULL;
                end else begin
                    emit.status       = padt_pkg::ST_ADDED;
                    wr_en             = 1'b1;
                    wr_addr           = IW'(r_count);
                    wr_data.ident     = r_req.action_id;
                    wr_data.multiple  = r_req.multiplier;
                    wr_data.countdown = r_req.multiplier;
                    n_count           = r_count + CW'(1);
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state; clear control at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_base       <= padt_pkg::RESET_PERIOD;
            r_period     <= padt_pkg::RESET_PERIOD;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_base       <= n_base;
            r_pend_valid <= n_pend_valid;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
        end
        r_idx       <= n_idx;
        r_req       <= n_req;
        r_pend_id   <= n_pend_id;
        r_pend_mult <= n_pend_mult;
    end

    padt_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    padt_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit         (emit),
        .i_period       (r_period),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ===== src/padt_checker.sv =====
// Port-level checks for the periodic action divider table, bound to the top level.
// Depends on padt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module padt_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input padt_pkg::t_req    i_req,
    input logic              o_result_valid,
    input padt_pkg::t_result o_result
);

    logic res_more;
    logic res_not_fired;
    logic add_taken;

    assign res_more      = o_result_valid && !o_result.last;
    assign res_not_fired = o_result_valid && (o_result.status != padt_pkg::ST_FIRED);
    assign add_taken     = start && !busy && (i_req.req_type == padt_pkg::REQ_ADD);

    // More results follow a non-final one, so the block stays busy
    `PADT_ASSERT(a_more_busy, i_clk, i_rst_n, res_more |-> busy)

    // Only a firing carries an interval
    `PADT_ASSERT(a_interval_fired, i_clk, i_rst_n, res_not_fired |-> (o_result.interval_us == 48'd0))

    // Table updates give one result only
    `PADT_ASSERT(a_single_last, i_clk, i_rst_n, res_not_fired |-> o_result.last)

    // An add always takes the sequencer
    `PADT_ASSERT(a_add_busy, i_clk, i_rst_n, add_taken |=> busy)

    // No strobe in the cycle after reset
    `PADT_ASSERT_ALWAYS(a_reset_quiet, i_clk, $past(!i_rst_n) |-> !o_result_valid)

endmodule

bind periodic_action_divider_table_core padt_checker u_padt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_req          (i_req),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for periodic_action_divider_table_core: a directed request table,
// then random phases under several periods; results are checked against a local model or a typed result.
// Depends on padt_pkg and the core RTL.
module testbench;

    localparam int         HALF_PERIOD   = 2;
    localparam int         RESET_CYCLES  = 5;
    localparam int         SETTLE_CYCLES = 40;    // longest add or remove plus output stage
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         PHASE_ITEMS   = 38;
    localparam int         N_PHASES      = 5;
    localparam logic [1:0] REQ_UNUSED    = 2'd3;
    localparam int         FROM_MODEL    = -1;
    localparam int         NO_RESULT     = 0;
    localparam int         ONE_RESULT    = 1;

    // One line of the directed table: a period write or a request repeated reps times
    typedef struct {
        bit             is_cfg;
        logic [31:0]    cfg_val;
        padt_pkg::t_req req;
        int             reps;
        int             n_typed;
        logic [2:0]     status;
    } t_script_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    padt_pkg::t_req    i_req;
    logic              i_cfg_we;
    logic [31:0]       i_cfg_wdata;
    logic              o_result_valid;
    padt_pkg::t_result o_result;

    // Local copy of the divider state
    logic [31:0] period_q;
    logic [31:0] base_left;
    int          n_entries;
    logic [7:0]  ent_id   [padt_pkg::TABLE_DEPTH];
    logic [15:0] ent_mult [padt_pkg::TABLE_DEPTH];
    logic [15:0] ent_cnt  [padt_pkg::TABLE_DEPTH];

    padt_pkg::t_result step_results[$];
    padt_pkg::t_result due_results[$];
    t_script_row       script[$];
    int                typed_n      = FROM_MODEL;
    padt_pkg::t_result typed_res    = '0;
    int                burst_left   = 0;
    int                quiet_cycles = 0;
    int                failures     = 0;

    periodic_action_divider_table_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (i_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic padt_pkg::t_result make_result(logic [2:0] st, logic [7:0] id,
                                                      logic [47:0] iv);
        padt_pkg::t_result res;
        res.status      = st;
        res.fired_id    = id;
        res.interval_us = iv;
        res.last        = 1'b0;
        return res;
    endfunction

    // Delete the entry with this id, closing the gap; report whether it was there
    function automatic bit drop_entry(logic [7:0] id);
        int i;
        int j;
        for (i = 0; i < n_entries; i++) begin
            if (ent_id[i] == id) begin
                for (j = i; j + 1 < n_entries; j++) begin
                    ent_id[j]   = ent_id[j + 1];
                    ent_mult[j] = ent_mult[j + 1];
                    ent_cnt[j]  = ent_cnt[j + 1];
                end
                n_entries--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Append one result to the results of the current request
    function automatic void add_step_result(padt_pkg::t_result res);
        step_results.insert(step_results.size(), res);
    endfunction

    // Apply one request to the local table and collect the results it causes
    function automatic void advance_table(padt_pkg::t_req r);
        int i;
        bit found;
        step_results.delete();
        case (r.req_type)
            padt_pkg::REQ_TICK: begin
                if (base_left < r.elapsed_us) begin
                    for (i = 0; i < n_entries; i++) begin
                        if (ent_cnt[i] == 16'd0) begin
                            ent_cnt[i] = ent_mult[i];
                            add_step_result(make_result(padt_pkg::ST_FIRED, ent_id[i],
                                (48'(ent_mult[i]) + 48'd1) * 48'(period_q)));
                        end else begin
                            ent_cnt[i] = ent_cnt[i] - 16'd1;
                        end
                    end
                    base_left = period_q;
                end else begin
                    base_left = base_left - r.elapsed_us;
                end
            end
            padt_pkg::REQ_ADD: begin
                void'(drop_entry(r.action_id));
                if (n_entries >= padt_pkg::TABLE_DEPTH) begin
                    add_step_result(make_result(padt_pkg::ST_FULL, r.action_id, '0));
                end else begin
                    ent_id[n_entries]   = r.action_id;
                    ent_mult[n_entries] = r.multiplier;
                    ent_cnt[n_entries]  = r.multiplier;
                    n_entries++;
                    add_step_result(make_result(padt_pkg::ST_ADDED, r.action_id, '0));
                end
            end
            padt_pkg::REQ_REMOVE: begin
                found = drop_entry(r.action_id);
                add_step_result(make_result(found ? padt_pkg::ST_REMOVED
                                                  : padt_pkg::ST_NOT_FOUND,
                                            r.action_id, '0));
            end
            default: begin
            end
        endcase
        // Mark the final result of the request
        if (step_results.size() != 0) begin
            step_results[step_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void compare_field(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            failures++;
        end
    endfunction

    function automatic void req_row(logic [1:0] kind, logic [31:0] elapsed, logic [7:0] id,
                                    logic [15:0] mult, int reps, int n_typed,
                                    logic [2:0] st);
        t_script_row row;
        row.is_cfg             = 1'b0;
        row.cfg_val            = '0;
        row.req.req_type       = kind;
        row.req.elapsed_us     = elapsed;
        row.req.action_id      = id;
        row.req.multiplier     = mult;
        row.reps               = reps;
        row.n_typed            = n_typed;
        row.status             = st;
        script.insert(script.size(), row);
    endfunction

    function automatic void cfg_row(logic [31:0] value);
        t_script_row row;
        row.is_cfg  = 1'b1;
        row.cfg_val = value;
        row.req     = '0;
        row.reps    = 0;
        row.n_typed = NO_RESULT;
        row.status  = padt_pkg::ST_FIRED;
        script.insert(script.size(), row);
    endfunction

    // Random request: mostly ids from a small pool so that adds collide and the table fills
    function automatic padt_pkg::t_req random_request();
        padt_pkg::t_req r;
        int             pick;
        pick = $urandom_range(0, 99);
        if (pick < 48)
            r.req_type = padt_pkg::REQ_TICK;
        else if (pick < 80)
            r.req_type = padt_pkg::REQ_ADD;
        else if (pick < 97)
            r.req_type = padt_pkg::REQ_REMOVE;
        else
            r.req_type = REQ_UNUSED;
        case ($urandom_range(0, 5))
            0:       r.elapsed_us = '0;
            1:       r.elapsed_us = $urandom;
            2:       r.elapsed_us = '1;
            3:       r.elapsed_us = period_q;
            4:       r.elapsed_us = period_q + 32'd1;
            default: r.elapsed_us = $urandom_range(0, period_q);
        endcase
        r.action_id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
        case ($urandom_range(0, 9))
            0:       r.multiplier = 16'($urandom);
            1, 2, 3: r.multiplier = 16'($urandom_range(0, 15));
            default: r.multiplier = 16'($urandom_range(0, 3));
        endcase
        return r;
    endfunction

    // Present one request in bursts with random gaps and hold it until taken
    task automatic send_item(padt_pkg::t_req r, int n_typed, padt_pkg::t_result typed);
        @(negedge i_clk);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                start = 1'b0;
                repeat ($urandom_range(1, 40)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        start     = 1'b1;
        i_req     = r;
        typed_n   = n_typed;
        typed_res = typed;
        burst_left--;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start, wait for every awaited result, then let the block finish its work
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_period(logic [31:0] value);
        settle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Check results, track register writes and predict each accepted request
    always @(posedge i_clk) begin
        padt_pkg::t_result want;
        if (!i_rst_n) begin
            period_q  = padt_pkg::RESET_PERIOD;
            base_left = padt_pkg::RESET_PERIOD;
            n_entries = 0;
        end else begin
            if (o_result_valid) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d id 0x%0h",
                             $time, o_result.status, o_result.fired_id);
                    failures++;
                end else begin
                    want = due_results.pop_front();
                    compare_field("status", 48'(want.status), 48'(o_result.status));
                    compare_field("fired_id", 48'(want.fired_id), 48'(o_result.fired_id));
                    compare_field("interval_us", want.interval_us, o_result.interval_us);
                    compare_field("last", 48'(want.last), 48'(o_result.last));
                end
            end
            if (i_cfg_we)
                period_q = i_cfg_wdata;
            if (start && !busy) begin
                advance_table(i_req);
                if (typed_n == FROM_MODEL) begin
                    foreach (step_results[k])
                        due_results.insert(due_results.size(), step_results[k]);
                end else if (typed_n == ONE_RESULT) begin
                    due_results.insert(due_results.size(), typed_res);
                end
            end
            if (o_result_valid || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Abort when nothing moves for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        padt_pkg::t_req    r;
        padt_pkg::t_result want;
        int                rep;
        int                phase;
        int                sent;
        logic [31:0]       phase_period [N_PHASES];

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;

        // Reset period: empty table, extremes of elapsed time, duplicate add
        req_row(padt_pkg::REQ_REMOVE, '0, 8'h00, '0, 1, ONE_RESULT, padt_pkg::ST_NOT_FOUND);
        req_row(padt_pkg::REQ_TICK, '0, '0, '0, 1, NO_RESULT, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, '1, '0, '0, 1, NO_RESULT, padt_pkg::ST_FIRED);
        req_row(REQ_UNUSED, '1, 8'hFF, 16'hFFFF, 1, NO_RESULT, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_ADD, '0, 8'hFF, 16'hFFFF, 1, ONE_RESULT, padt_pkg::ST_ADDED);
        req_row(padt_pkg::REQ_ADD, '0, 8'h00, 16'h0000, 1, ONE_RESULT, padt_pkg::ST_ADDED);
        req_row(padt_pkg::REQ_ADD, '0, 8'hFF, 16'd1, 1, ONE_RESULT, padt_pkg::ST_ADDED);
        req_row(padt_pkg::REQ_TICK, 32'd1000001, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, 32'd1000000, '0, '0, 1, NO_RESULT, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, 32'd1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_REMOVE, '0, 8'h00, '0, 1, ONE_RESULT, padt_pkg::ST_REMOVED);
        req_row(padt_pkg::REQ_REMOVE, '0, 8'h00, '0, 1, ONE_RESULT, padt_pkg::ST_NOT_FOUND);
        // Largest period
        cfg_row(32'hFFFF_FFFF);
        req_row(padt_pkg::REQ_ADD, '0, 8'h80, 16'hFFFF, 1, ONE_RESULT, padt_pkg::ST_ADDED);
        req_row(padt_pkg::REQ_TICK, '1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, '1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, 32'd1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        // Zero period, then a full table where every entry fires on one impulse
        cfg_row(32'd0);
        req_row(padt_pkg::REQ_TICK, '1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, 32'd1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, 32'd1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_REMOVE, '0, 8'hFF, '0, 1, ONE_RESULT, padt_pkg::ST_REMOVED);
        req_row(padt_pkg::REQ_REMOVE, '0, 8'h80, '0, 1, ONE_RESULT, padt_pkg::ST_REMOVED);
        req_row(padt_pkg::REQ_ADD, '0, 8'h40, 16'd0, padt_pkg::TABLE_DEPTH, ONE_RESULT,
                padt_pkg::ST_ADDED);
        req_row(padt_pkg::REQ_ADD, '0, 8'h55, 16'd7, 1, ONE_RESULT, padt_pkg::ST_FULL);
        req_row(padt_pkg::REQ_ADD, '0, 8'h40, 16'd0, 1, ONE_RESULT, padt_pkg::ST_ADDED);
        req_row(padt_pkg::REQ_TICK, 32'd1, '0, '0, 1, FROM_MODEL, padt_pkg::ST_FIRED);
        req_row(padt_pkg::REQ_TICK, '0, '0, '0, 1, NO_RESULT, padt_pkg::ST_FIRED);

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                write_period(script[k].cfg_val);
            end else begin
                for (rep = 0; rep < script[k].reps; rep++) begin
                    r           = script[k].req;
                    r.action_id = r.action_id + 8'(rep);
                    want        = make_result(script[k].status, r.action_id, '0);
                    want.last   = 1'b1;
                    send_item(r, script[k].n_typed, want);
                end
            end
        end

        // Random phases, one period setting each
        phase_period = '{32'd1, 32'($urandom_range(2, 5000)), 32'hFFFF_FFFF, 32'd0, $urandom};
        for (phase = 0; phase < N_PHASES; phase++) begin
            write_period(phase_period[phase]);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = random_request();
                send_item(r, FROM_MODEL, '0);
                if (r.req_type != REQ_UNUSED)
                    sent++;
            end
        end

        settle();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
